// ----- hw/rtl/mdc2_pkg.sv -----
// Package for the MDC-2 hash block: DES tables, key preparation and round helpers.
// Used by mdc2_des_core and mdc2_des_hash_top; no dependencies.
package mdc2_pkg;

  localparam logic [63:0] InitA = 64'h5252525252525252;
  localparam logic [63:0] InitB = 64'h2525252525252525;
  localparam logic [63:0] PadBlock = 64'h8000000000000000;
  localparam int unsigned NumRounds = 16;
  localparam int unsigned RoundW = $clog2(NumRounds);

  typedef logic [7:0] perm64_t [64];
  typedef logic [7:0] perm56_t [56];
  typedef logic [7:0] perm48_t [48];
  typedef logic [7:0] perm32_t [32];
  typedef logic [3:0] sbox_t [8][64];

  localparam perm64_t TIp = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam perm64_t TFp = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam perm48_t TE = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam perm32_t TP = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam perm56_t TPc1 = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam perm48_t TPc2 = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam logic [15:0] TRotTwo = 16'b0011_1111_0111_1110;
  localparam sbox_t TSbox = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(TPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(TPc2[i])];
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] v, input logic two);
    return two ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0] b;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(TE[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      s[31-4*i -: 4] = TSbox[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TP[i])];
    return p;
  endfunction

  function automatic logic [63:0] key_parity(input logic [63:0] k);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i+1 +: 7] = k[8*i+1 +: 7];
      r[8*i] = ~(^k[8*i+1 +: 7]);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mdc2_if.sv -----
// Valid/ready channel interface with a generic payload type.
// Depends on nothing; the payload type is a parameter.
interface mdc2_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/mdc2_des_core.sv -----
// Two DES encryptions side by side, one round per cycle, sharing one round sequencer.
// Depends on mdc2_pkg.
module mdc2_des_core
  import mdc2_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_a_i,
  input  logic [63:0] key_b_i,
  input  logic [63:0] block_i,
  output logic        done_o,
  output logic [63:0] ct_a_o,
  output logic [63:0] ct_b_o
);

  logic [RoundW-1:0] round_q, round_d;
  logic busy_q, busy_d;
  logic [27:0] ca_q, da_q, cb_q, db_q, ca_d, da_d, cb_d, db_d;
  logic [31:0] la_q, ra_q, lb_q, rb_q, la_d, ra_d, lb_d, rb_d;
  logic [55:0] cda, cdb;
  logic [63:0] ipb;
  logic two;

  always_comb begin
    cda = perm_pc1(key_a_i);
    cdb = perm_pc1(key_b_i);
    ipb = perm_ip(block_i);
    two = TRotTwo[~round_q];
    busy_d = busy_q;
    round_d = round_q;
    ca_d = ca_q; da_d = da_q; cb_d = cb_q; db_d = db_q;
    la_d = la_q; ra_d = ra_q; lb_d = lb_q; rb_d = rb_q;
    if (start_i) begin
      busy_d = 1'b1;
      round_d = '0;
      ca_d = cda[55:28]; da_d = cda[27:0];
      cb_d = cdb[55:28]; db_d = cdb[27:0];
      la_d = ipb[63:32]; ra_d = ipb[31:0];
      lb_d = ipb[63:32]; rb_d = ipb[31:0];
    end else if (busy_q) begin
      ca_d = rot28(ca_q, two); da_d = rot28(da_q, two);
      cb_d = rot28(cb_q, two); db_d = rot28(db_q, two);
      la_d = ra_q; ra_d = la_q ^ feistel(ra_q, perm_pc2({ca_d, da_d}));
      lb_d = rb_q; rb_d = lb_q ^ feistel(rb_q, perm_pc2({cb_d, db_d}));
      round_d = round_q + 1'b1;
      if (round_q == RoundW'(NumRounds - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      round_q <= '0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      round_q <= round_d;
      done_o <= busy_q && (round_q == RoundW'(NumRounds - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q <= ca_d; da_q <= da_d; cb_q <= cb_d; db_q <= db_d;
    la_q <= la_d; ra_q <= ra_d; lb_q <= lb_d; rb_q <= rb_d;
  end

  assign ct_a_o = perm_fp({ra_q, la_q});
  assign ct_b_o = perm_fp({rb_q, lb_q});

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_q)
    else $error("done while rounds still running");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy_q))
    else $error("done without a run");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q && round_q == '0)
    else $error("start did not begin a run");

endmodule

// ----- hw/rtl/mdc2_des_hash_top.sv -----
// MDC-2 hash top level: padding, key preparation, chaining and digest output.
// Depends on mdc2_pkg, mdc2_if and mdc2_des_core.
//
//  channel  dir  payload                                      transfer
//  in_if    in   message_block[63:0] valid_bytes[3:0] final   valid & ready
//  cfg_if   in   padding_method                               valid & ready
//  out_if   out  digest_word[63:0] digest_last                valid & ready
//
// A block passes through the transfer, a core load, 16 DES rounds for both halves in
// parallel, then the chaining update. Method 2 on a full final block adds a second
// compression. After the final item the two digest words leave in order; input
// waits until both are taken. Reset sets the chaining values to their initial constants
// and the register to 0.
module mdc2_des_hash_top
  import mdc2_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mdc2_if.sink   in_if,
  mdc2_if.sink   cfg_if,
  mdc2_if.source out_if
);

  typedef enum logic [2:0] {StIdle, StStart, StRun, StOut0, StOut1} state_e;

  state_e state_q;
  logic pad_q;
  logic [63:0] a_q, b_q, m_q;
  logic fin_q, extra_q;
  logic core_start, core_done;
  logic [63:0] ka, kb, ct_a, ct_b, v, w;
  logic [3:0] vb;
  logic [63:0] mask, mpad;

  assign in_if.ready = (state_q == StIdle);
  assign cfg_if.ready = 1'b1;
  assign core_start = (state_q == StStart);
  assign out_if.valid = (state_q == StOut0) || (state_q == StOut1);
  assign out_if.data.digest_word = (state_q == StOut1) ? b_q : a_q;
  assign out_if.data.digest_last = (state_q == StOut1);

  always_comb begin
    ka = key_parity({(a_q[63:56] & 8'h9f) | 8'h40, a_q[55:0]});
    kb = key_parity({(b_q[63:56] & 8'h9f) | 8'h20, b_q[55:0]});
    v = ct_a ^ m_q;
    w = ct_b ^ m_q;
    vb = (in_if.data.valid_bytes > 4'd8) ? 4'd8 : in_if.data.valid_bytes;
    mask = ~(64'hFFFFFFFFFFFFFFFF >> {vb, 3'b000});
    if (vb == 4'd8) mask = '1;
    mpad = in_if.data.message_block & mask;
    if (pad_q && vb != 4'd8) mpad = mpad | (PadBlock >> {vb, 3'b000});
  end

  mdc2_des_core u_core (
    .clk_i, .rst_ni,
    .start_i(core_start), .key_a_i(ka), .key_b_i(kb), .block_i(m_q),
    .done_o(core_done), .ct_a_o(ct_a), .ct_b_o(ct_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pad_q <= 1'b0;
      a_q <= InitA;
      b_q <= InitB;
      fin_q <= 1'b0;
      extra_q <= 1'b0;
      m_q <= '0;
    end else begin
      if (cfg_if.valid) pad_q <= cfg_if.data;
      unique case (state_q)
        StIdle: begin
          if (in_if.valid) begin
            fin_q <= in_if.data.final_block;
            if (!in_if.data.final_block) begin
              m_q <= in_if.data.message_block;
              extra_q <= 1'b0;
              state_q <= StStart;
            end else begin
              m_q <= mpad;
              extra_q <= pad_q && (vb == 4'd8);
              state_q <= (!pad_q && vb == 4'd0) ? StOut0 : StStart;
            end
          end
        end
        StStart: state_q <= StRun;
        StRun: begin
          if (core_done) begin
            a_q <= {v[63:32], w[31:0]};
            b_q <= {w[63:32], v[31:0]};
            if (extra_q) begin
              extra_q <= 1'b0;
              m_q <= PadBlock;
              state_q <= StStart;
            end else begin
              state_q <= fin_q ? StOut0 : StIdle;
            end
          end
        end
        StOut0: if (out_if.ready) state_q <= StOut1;
        StOut1: begin
          if (out_if.ready) begin
            a_q <= InitA;
            b_q <= InitB;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut1 && out_if.ready) |=> a_q == InitA && b_q == InitB)
    else $error("chaining not reset after digest");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> state_q == StRun)
    else $error("DES finished outside a run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut0 && out_if.ready) |=> state_q == StOut1)
    else $error("second digest word skipped");

endmodule
